// ----- rtl/lskv_pkg.sv -----
// Shared constants, types and state codes for the linear-search key/value table.
`timescale 1ns / 1ps
package lskv_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int KEY_WIDTH   = 32;

  localparam int KEY_PORT_W = 32;
  localparam int VALUE_W    = 32;
  localparam int MODE_W     = 2;
  localparam int STATUS_W   = 3;
  localparam int LIVE_W     = 5;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  localparam logic [MODE_W-1:0] MODE_SET   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_GET   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ERASE = 2'd2;
  localparam logic [MODE_W-1:0] MODE_NONE  = 2'd3;

  localparam logic [STATUS_W-1:0] ST_UPDATED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_REMOVED  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_MISS     = 3'd4;

  typedef logic [IDX_W-1:0]          idx_t;
  typedef logic [CNT_W-1:0]          cnt_t;
  typedef logic [KEY_WIDTH-1:0]      key_w_t;
  typedef logic signed [VALUE_W-1:0] value_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_GET,
    S_MOVE,
    S_RESP
  } lskv_state_t;

  typedef struct packed {
    logic   we;
    idx_t   waddr;
    key_w_t wdata;
    idx_t   raddr;
  } key_mem_cmd_t;

  typedef struct packed {
    logic   we;
    idx_t   waddr;
    value_t wdata;
    idx_t   raddr;
  } value_mem_cmd_t;

endpackage

// ----- rtl/lskv_ifs.sv -----
// Valid/ready channel interfaces for the request and response words.
`timescale 1ns / 1ps
interface lskv_req_if
  import lskv_pkg::*;
;
  logic                       valid;
  logic                       ready;
  logic [MODE_W-1:0]          mode;
  logic [KEY_PORT_W-1:0]      key;
  logic signed [VALUE_W-1:0]  value;

  modport source (output valid, output mode, output key, output value, input ready);
  modport sink   (input valid, input mode, input key, input value, output ready);
endinterface

interface lskv_rsp_if
  import lskv_pkg::*;
;
  logic                       valid;
  logic                       ready;
  logic [STATUS_W-1:0]        status;
  logic                       found;
  logic signed [VALUE_W-1:0]  read_value;
  logic [LIVE_W-1:0]          live_count;

  modport source (output valid, output status, output found, output read_value,
                  output live_count, input ready);
  modport sink   (input valid, input status, input found, input read_value,
                  input live_count, output ready);
endinterface

// ----- rtl/linear_search_key_value_table_top.sv -----
// Top level of the linear-search key/value table: key and value memories and their sequencer.
// Each request word (set, get or erase on a key) is answered by exactly one response word.
// A request scans the live entries one per cycle through the key memory's single read port.
// Its steps are accept, scan, decide, a value or last-entry read on get and erase, and the
// response load; a word with the unused mode goes from accept straight to the response load.
// The response sits in an output register, so the scan of the next request is not held
// up until the response is read, though a new request is taken only once the previous
// one has been loaded into that register. Memories need no clearing after reset: only
// entries below the live count are ever read.
`timescale 1ns / 1ps
module linear_search_key_value_table_top
  import lskv_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  lskv_req_if.sink   req,
  lskv_rsp_if.source rsp
);

  key_mem_cmd_t   kmem;
  value_mem_cmd_t vmem;
  key_w_t         kmem_rdata;
  value_t         vmem_rdata;

  lskv_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .rsp        (rsp),
    .kmem       (kmem),
    .kmem_rdata (kmem_rdata),
    .vmem       (vmem),
    .vmem_rdata (vmem_rdata)
  );

  lskv_ram #(
    .WIDTH (KEY_WIDTH),
    .DEPTH (TABLE_DEPTH)
  ) u_key_ram (
    .clk   (clk),
    .we    (kmem.we),
    .waddr (kmem.waddr),
    .wdata (kmem.wdata),
    .raddr (kmem.raddr),
    .rdata (kmem_rdata)
  );

  lskv_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (TABLE_DEPTH)
  ) u_value_ram (
    .clk   (clk),
    .we    (vmem.we),
    .waddr (vmem.waddr),
    .wdata (vmem.wdata),
    .raddr (vmem.raddr),
    .rdata (vmem_rdata)
  );

endmodule

// ----- rtl/lskv_ram.sv -----
// Simple dual-port synchronous RAM with one write port and a registered read port.
`timescale 1ns / 1ps
module lskv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/lskv_ctrl.sv -----
// Sequencer that scans, updates and compacts the table and registers each response word.
`timescale 1ns / 1ps
module lskv_ctrl
  import lskv_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  lskv_req_if.sink       req,
  lskv_rsp_if.source     rsp,
  output key_mem_cmd_t   kmem,
  input  key_w_t         kmem_rdata,
  output value_mem_cmd_t vmem,
  input  value_t         vmem_rdata
);

  lskv_state_t          state, state_next;
  cnt_t                 idx, idx_next;
  cnt_t                 count, count_next;
  logic [MODE_W-1:0]    mode_r, mode_next;
  key_w_t               key_r, key_next;
  value_t               value_r, value_next;
  logic                 found_r, found_next;
  logic [STATUS_W-1:0]  status_r, status_next;
  value_t               rd_val, rd_val_next;
  logic                 out_valid;
  logic                 load_out;
  cnt_t                 idx_inc;
  cnt_t                 last_slot;

  assign idx_inc   = idx + cnt_t'(1);
  assign last_slot = count - cnt_t'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    idx      <= idx_next;
    mode_r   <= mode_next;
    key_r    <= key_next;
    value_r  <= value_next;
    found_r  <= found_next;
    status_r <= status_next;
    rd_val   <= rd_val_next;
  end

  always_comb begin
    state_next  = state;
    idx_next    = idx;
    count_next  = count;
    mode_next   = mode_r;
    key_next    = key_r;
    value_next  = value_r;
    found_next  = found_r;
    status_next = status_r;
    rd_val_next = rd_val;
    kmem        = '0;
    vmem        = '0;
    kmem.raddr  = idx[IDX_W-1:0];
    vmem.raddr  = idx[IDX_W-1:0];
    req.ready   = 1'b0;
    load_out    = 1'b0;
    unique case (state)
      S_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          mode_next   = req.mode;
          key_next    = key_w_t'(req.key);
          value_next  = req.value;
          idx_next    = '0;
          found_next  = 1'b0;
          rd_val_next = '0;
          kmem.raddr  = '0;
          if (req.mode == MODE_NONE) begin
            status_next = ST_MISS;
            state_next  = S_RESP;
          end else if (count == '0) begin
            state_next = S_DECIDE;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (kmem_rdata == key_r) begin
          found_next = 1'b1;
          state_next = S_DECIDE;
        end else if (idx_inc == count) begin
          state_next = S_DECIDE;
        end else begin
          idx_next   = idx_inc;
          kmem.raddr = idx_inc[IDX_W-1:0];
        end
      end
      S_DECIDE: begin
        state_next  = S_RESP;
        status_next = ST_MISS;
        unique case (mode_r)
          MODE_SET: begin
            if (found_r) begin
              vmem.we     = 1'b1;
              vmem.waddr  = idx[IDX_W-1:0];
              vmem.wdata  = value_r;
              status_next = ST_UPDATED;
            end else if (count < cnt_t'(TABLE_DEPTH)) begin
              kmem.we     = 1'b1;
              kmem.waddr  = count[IDX_W-1:0];
              kmem.wdata  = key_r;
              vmem.we     = 1'b1;
              vmem.waddr  = count[IDX_W-1:0];
              vmem.wdata  = value_r;
              count_next  = count + cnt_t'(1);
              status_next = ST_INSERTED;
            end
          end
          MODE_GET: begin
            if (found_r) begin
              vmem.raddr = idx[IDX_W-1:0];
              state_next = S_GET;
            end
          end
          MODE_ERASE: begin
            if (found_r) begin
              kmem.raddr = last_slot[IDX_W-1:0];
              vmem.raddr = last_slot[IDX_W-1:0];
              state_next = S_MOVE;
            end
          end
          default: begin
            state_next = S_RESP;
          end
        endcase
      end
      S_GET: begin
        rd_val_next = vmem_rdata;
        status_next = ST_FOUND;
        state_next  = S_RESP;
      end
      S_MOVE: begin
        kmem.we     = 1'b1;
        kmem.waddr  = idx[IDX_W-1:0];
        kmem.wdata  = kmem_rdata;
        vmem.we     = 1'b1;
        vmem.waddr  = idx[IDX_W-1:0];
        vmem.wdata  = vmem_rdata;
        count_next  = count - cnt_t'(1);
        status_next = ST_REMOVED;
        state_next  = S_RESP;
      end
      S_RESP: begin
        if (!out_valid || rsp.ready) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      rsp.status     <= status_r;
      rsp.found      <= found_r && (status_r != ST_MISS);
      rsp.read_value <= rd_val;
      rsp.live_count <= LIVE_W'(count);
    end
  end

  assign rsp.valid = out_valid;

endmodule

// ----- rtl/lskv_checker.sv -----
// Port-level checks on the response words of the key/value table, bound to the top level.
`timescale 1ns / 1ps
module lskv_checker
  import lskv_pkg::*;
(
  input logic                      clk,
  input logic                      rst,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [STATUS_W-1:0]       status,
  input logic                      found,
  input logic signed [VALUE_W-1:0] read_value,
  input logic [LIVE_W-1:0]         live_count
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(live_count))
    else $error("response word changed while stalled");

  a_found: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (found == (status == ST_UPDATED || status == ST_FOUND ||
                             status == ST_REMOVED)))
    else $error("found flag disagrees with status");

  a_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_FOUND) |-> read_value == '0)
    else $error("read value set on a response that is not a successful get");

  a_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> live_count <= LIVE_W'(TABLE_DEPTH))
    else $error("live count beyond table depth");

  a_change: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_INSERTED) |-> live_count != '0)
    else $error("insert left the table empty");

endmodule

bind linear_search_key_value_table_top lskv_checker u_lskv_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (rsp.valid),
  .out_ready  (rsp.ready),
  .status     (rsp.status),
  .found      (rsp.found),
  .read_value (rsp.read_value),
  .live_count (rsp.live_count)
);
